// ===== rtl/efp_pkg.sv =====
// ============================================================================
// efp_pkg
// Shared constants, register indexes and the exp2 fraction table of the
// exponential/Fermi pulse template generator.
// ============================================================================
`default_nettype none

package efp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PEAK_GAIN     = 3'd0;
  localparam logic [2:0] CFG_START_TIME    = 3'd1;
  localparam logic [2:0] CFG_INV_RISE_TAU  = 3'd2;
  localparam logic [2:0] CFG_INV_DECAY_TAU = 3'd3;
  localparam logic [2:0] CFG_BASELINE      = 3'd4;
  localparam logic [2:0] CFG_REFL_DELAY    = 3'd5;
  localparam logic [2:0] CFG_REFL_GAIN     = 3'd6;
  localparam logic [2:0] CFG_REFL_MODE     = 3'd7;

  // Fixed-point constants (Q.16)
  localparam logic [16:0] LOG2E_Q16      = 17'd94548;
  localparam logic [16:0] TAIL_Q16       = 17'd655;
  localparam logic [13:0] INV_WIDTH2_Q16 = 14'd14564;
  localparam logic [16:0] ONE_Q16        = 17'd65536;

  // 2^(-2^-k) in Q.16, k = 1..8
  localparam logic [15:0] POW2_NEG_FRAC [8] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757,
    16'd64132, 16'd64830, 16'd65182, 16'd65359
  };

  typedef logic [30:0] frac_tbl_t [256];

  // 2^-f for an 8-bit fraction f, in Q.30, built by the same rounded
  // product chain as the bit-by-bit form.
  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t  tbl;
    logic [63:0] r;
    for (int f = 0; f < 256; f++) begin
      r = 64'd1 << 30;
      for (int k = 0; k < 8; k++) begin
        if (f[7-k]) begin
          r = (r * 64'(POW2_NEG_FRAC[k]) + 64'd32768) >> 16;
        end
      end
      tbl[f] = r[30:0];
    end
    return tbl;
  endfunction

  localparam frac_tbl_t EXP2_FRAC_TBL = build_frac_tbl();

endpackage

`default_nettype wire

// ===== rtl/efp_exp.sv =====
// ============================================================================
// efp_exp
// Three-stage exp(-x) unit: x in Q.20 (26 bits plus overflow flag),
// result in Q.16 (0..65536).
// ============================================================================
`default_nettype none

module efp_exp (
  input  wire logic        clk_i,
  input  wire logic [2:0]  en_i,
  input  wire logic [25:0] x_i,
  input  wire logic        big_i,
  output logic      [16:0] e_o
);

  logic [42:0] prod;
  logic [14:0] y_d, y_q;
  logic        big_q;
  logic [30:0] r_d, r_q;
  logic [4:0]  n_q;
  logic        zero_d, zero_q;
  logic [30:0] r_shift;
  logic [30:0] r_round;
  logic [16:0] e_d, e_q;

  // x * log2(e): integer part in y[14:8], fraction in y[7:0]
  assign prod = 43'(x_i) * 43'(efp_pkg::LOG2E_Q16);
  assign y_d  = prod[42:28];

  assign zero_d = big_q | (y_q[14:8] >= 7'd31);
  assign r_d    = efp_pkg::EXP2_FRAC_TBL[y_q[7:0]];

  assign r_shift = r_q >> n_q;
  assign r_round = r_shift + 31'd8192;
  assign e_d     = zero_q ? 17'd0 : r_round[30:14];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      y_q   <= y_d;
      big_q <= big_i;
    end
    if (en_i[1]) begin
      r_q    <= r_d;
      n_q    <= y_q[12:8];
      zero_q <= zero_d;
    end
    if (en_i[2]) begin
      e_q <= e_d;
    end
  end

  assign e_o = e_q;

endmodule

`default_nettype wire

// ===== rtl/efp_div.sv =====
// ============================================================================
// efp_div
// Pipelined restoring divider: 34-bit dividend by 18-bit divisor, 18-bit
// quotient, three quotient bits per stage over six stages.
// ============================================================================
`default_nettype none

module efp_div (
  input  wire logic        clk_i,
  input  wire logic [5:0]  en_i,
  input  wire logic [33:0] num_i,
  input  wire logic [17:0] den_i,
  output logic      [17:0] quo_o
);

  localparam int Stages = 6;
  localparam int Steps  = 3;
  localparam int QBits  = Stages * Steps;

  logic [16:0] rem_q [Stages];
  logic [17:0] lo_q  [Stages];
  logic [17:0] q_q   [Stages];
  logic [17:0] den_q [Stages];

  for (genvar j = 0; j < Stages; j++) begin : g_stage
    logic [16:0] rem_in, rem_out;
    logic [17:0] lo_in, q_in, den_in, q_out, trial;

    if (j == 0) begin : g_first
      // dividend is known to be below den * 2^18, so the top part fits
      assign rem_in = {1'b0, num_i[33:18]};
      assign lo_in  = num_i[17:0];
      assign q_in   = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign lo_in  = lo_q[j-1];
      assign q_in   = q_q[j-1];
      assign den_in = den_q[j-1];
    end

    always_comb begin
      rem_out = rem_in;
      q_out   = q_in;
      trial   = '0;
      for (int s = 0; s < Steps; s++) begin
        trial = {rem_out, lo_in[QBits-1-Steps*j-s]};
        if (trial >= den_in) begin
          rem_out = 17'(trial - den_in);
          q_out[QBits-1-Steps*j-s] = 1'b1;
        end else begin
          rem_out = trial[16:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_out;
        lo_q[j]  <= lo_in;
        q_q[j]   <= q_out;
        den_q[j] <= den_in;
      end
    end
  end

  assign quo_o = q_q[Stages-1];

endmodule

`default_nettype wire

// ===== rtl/exp_fermi_pulse_template_generator.sv =====
// ============================================================================
// exp_fermi_pulse_template_generator
// Evaluates gain * exp decay * Fermi rise + baseline, optionally with a tail
// constant and a Gaussian reflection dip, at one sample time per word.
// ============================================================================
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes a signed Q10.6 sample time.
//   Output channel (out_valid_o/out_ready_i) returns the Q24.8 pulse value
//   and a saturation flag, one result word per input word, in order.
//   The pipe registers, in order: difference, products, exp argument, a
//   three-stage exp unit (decay, rise and reflection in parallel), gain
//   products, a six-stage divider for the Fermi quotient, final product,
//   sum and clip. Throughput is one word per cycle unless the receiver
//   stalls with the pipe full; the divider and exp units are fully pipelined.
//   Each stage advances when it is empty or its successor advances, so
//   bubbles squeeze out and new words enter while a result waits; when the
//   receiver stalls with the pipe full, in_ready_o drops.
//   Reset empties the pipe and loads register defaults. Write registers via
//   cfg_we_i only while the pipe is empty.
// ============================================================================
`default_nettype none

module exp_fermi_pulse_template_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] pulse_value_o,
  output logic             saturated_o
);

  localparam int NumStages = 15;

  // Configuration registers
  logic [31:0] peak_gain_q;
  logic [15:0] start_time_q;
  logic [15:0] inv_rise_tau_q;
  logic [15:0] inv_decay_tau_q;
  logic [23:0] baseline_q;
  logic [9:0]  refl_delay_q;
  logic [31:0] refl_gain_q;
  logic        refl_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_gain_q     <= '0;
      start_time_q    <= '0;
      inv_rise_tau_q  <= 16'd16384;
      inv_decay_tau_q <= 16'd16384;
      baseline_q      <= '0;
      refl_delay_q    <= 10'd320;
      refl_gain_q     <= '0;
      refl_mode_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        efp_pkg::CFG_PEAK_GAIN:     peak_gain_q     <= cfg_wdata_i;
        efp_pkg::CFG_START_TIME:    start_time_q    <= cfg_wdata_i[15:0];
        efp_pkg::CFG_INV_RISE_TAU:  inv_rise_tau_q  <= cfg_wdata_i[15:0];
        efp_pkg::CFG_INV_DECAY_TAU: inv_decay_tau_q <= cfg_wdata_i[15:0];
        efp_pkg::CFG_BASELINE:      baseline_q      <= cfg_wdata_i[23:0];
        efp_pkg::CFG_REFL_DELAY:    refl_delay_q    <= cfg_wdata_i[9:0];
        efp_pkg::CFG_REFL_GAIN:     refl_gain_q     <= cfg_wdata_i;
        efp_pkg::CFG_REFL_MODE:     refl_mode_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stage valids and advance enables
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = ~v_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 0: time difference and its magnitudes
  logic [16:0] diff, dmag_d, rdiff, rmag_full;
  logic [15:0] dt_d;
  logic        dneg_q;
  logic [16:0] dmag_q;
  logic [15:0] dt_q, rmag_q;

  assign diff      = {sample_time_i[15], sample_time_i} - {start_time_q[15], start_time_q};
  assign dmag_d    = diff[16] ? 17'(-diff) : diff;
  assign dt_d      = diff[16] ? 16'd0 : diff[15:0];
  assign rdiff     = {1'b0, dt_d} - {7'd0, refl_delay_q};
  assign rmag_full = rdiff[16] ? 17'(-rdiff) : rdiff;

  // Stage 1: decay, rise and reflection products
  logic [31:0] xd1_q, xu1_q, sq1_q;
  logic [32:0] xu_prod;
  logic        uneg_q [1:5];

  assign xu_prod = 33'(dmag_q) * 33'(inv_rise_tau_q);

  // Stage 2: exp arguments, clipped to 26 bits with an overflow flag
  logic [45:0] xr_prod;
  logic [25:0] xd2_q, xu2_q, xr2_q;
  logic        dbig2_q, ubig2_q, rbig2_q;

  assign xr_prod = 46'(sq1_q) * 46'(efp_pkg::INV_WIDTH2_Q16);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dneg_q <= diff[16];
      dmag_q <= dmag_d;
      dt_q   <= dt_d;
      rmag_q <= rmag_full[15:0];
    end
    if (en[1]) begin
      xd1_q     <= 32'(dt_q) * 32'(inv_decay_tau_q);
      xu1_q     <= xu_prod[31:0];
      sq1_q     <= 32'(rmag_q) * 32'(rmag_q);
      uneg_q[1] <= dneg_q;
    end
    if (en[2]) begin
      xd2_q   <= xd1_q[25:0];
      dbig2_q <= |xd1_q[31:26];
      xu2_q   <= xu1_q[25:0];
      ubig2_q <= |xu1_q[31:26];
      xr2_q   <= xr_prod[33:8];
      rbig2_q <= |xr_prod[45:34];
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        uneg_q[k] <= uneg_q[k-1];
      end
    end
  end

  // Stages 3..5: exp units
  logic [16:0] e_dec, e_rise, e_refl;

  efp_exp u_exp_dec (
    .clk_i (clk_i),
    .en_i  (en[5:3]),
    .x_i   (xd2_q),
    .big_i (dbig2_q),
    .e_o   (e_dec)
  );

  efp_exp u_exp_rise (
    .clk_i (clk_i),
    .en_i  (en[5:3]),
    .x_i   (xu2_q),
    .big_i (ubig2_q),
    .e_o   (e_rise)
  );

  efp_exp u_exp_refl (
    .clk_i (clk_i),
    .en_i  (en[5:3]),
    .x_i   (xr2_q),
    .big_i (rbig2_q),
    .e_o   (e_refl)
  );

  // Stage 6: gain products, Fermi dividend and divisor
  logic [16:0] dec;
  logic [48:0] a_prod, r_prod;
  logic [17:0] den_d;
  logic [33:0] num_d;
  logic [33:0] num6_q;
  logic [17:0] den6_q;
  logic [32:0] a_q  [6:12];
  logic [24:0] rr_q [6:13];

  assign dec    = e_dec + (refl_mode_q ? efp_pkg::TAIL_Q16 : 17'd0);
  assign a_prod = 49'(peak_gain_q) * 49'(dec) + 49'd32768;
  assign r_prod = 49'(refl_gain_q) * 49'(e_refl) + 49'(24'h800000);
  assign den_d  = 18'(efp_pkg::ONE_Q16) + 18'(e_rise);
  // negative rise argument: e / (1 + e); otherwise 1 / (1 + e)
  assign num_d  = uneg_q[5] ? ({1'b0, e_rise, 16'd0} + 34'(den_d[17:1]))
                            : ((34'd1 << 32) + 34'(den_d[17:1]));

  // Stages 7..12: Fermi quotient
  logic [17:0] fer;

  efp_div u_div (
    .clk_i (clk_i),
    .en_i  (en[12:7]),
    .num_i (num6_q),
    .den_i (den6_q),
    .quo_o (fer)
  );

  // Stage 13: main term
  logic [49:0] m_prod;
  logic [25:0] main13_q;

  assign m_prod = 50'(a_q[12]) * 50'(fer[16:0]) + 50'(24'h800000);

  // Stage 14: sum and clip
  logic [33:0] sum;
  logic [31:0] pulse_d;
  logic        sat_d;
  logic [31:0] pulse_q;
  logic        sat_q;

  always_comb begin
    sum = {8'd0, main13_q} + {{10{baseline_q[23]}}, baseline_q}
          - (refl_mode_q ? {9'd0, rr_q[13]} : 34'd0);
    if (!sum[33] && (sum[32:31] != 2'b00)) begin
      pulse_d = 32'h7fff_ffff;
      sat_d   = 1'b1;
    end else if (sum[33] && (sum[32:31] != 2'b11)) begin
      pulse_d = 32'h8000_0000;
      sat_d   = 1'b1;
    end else begin
      pulse_d = sum[31:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      a_q[6]  <= a_prod[48:16];
      rr_q[6] <= r_prod[48:24];
      num6_q  <= num_d;
      den6_q  <= den_d;
    end
    for (int k = 7; k <= 12; k++) begin
      if (en[k]) begin
        a_q[k]  <= a_q[k-1];
        rr_q[k] <= rr_q[k-1];
      end
    end
    if (en[13]) begin
      main13_q <= m_prod[49:24];
      rr_q[13] <= rr_q[12];
    end
    if (en[14]) begin
      pulse_q <= pulse_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o   = v_q[NumStages-1];
  assign pulse_value_o = pulse_q;
  assign saturated_o   = sat_q;

`ifndef NO_ASSERTIONS
  // An empty output stage must open the whole pipe to new words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipe blocked with empty output stage");

  // exp results never exceed one in Q.16
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> (e_dec <= 17'd65536 && e_rise <= 17'd65536 && e_refl <= 17'd65536))
    else $error("exp unit result above one");

  // Fermi quotient stays within one in Q.16
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[12] |-> (fer <= 18'd65536))
    else $error("Fermi quotient out of range");

  // A clipped result sits on a range limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (pulse_value_o == 32'h7fff_ffff || pulse_value_o == 32'h8000_0000))
    else $error("saturation flag without clipped value");
`endif

endmodule

`default_nettype wire

// ===== verif/exp_fermi_pulse_template_generator_test.sv =====
// ============================================================================
// exp_fermi_pulse_template_generator_test
// Drives sample times through the pulse template generator under random
// stalls on both channels, predicts every pulse value and saturation flag
// in fixed point, and compares each result word with the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module exp_fermi_pulse_template_generator_test;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } pulse_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY        = 15;

  localparam logic [15:0] FRAC_STEP [8] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757,
    16'd64132, 16'd64830, 16'd65182, 16'd65359
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] sample_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] pulse_value_o;
  logic        saturated_o;

  // register shadow
  logic [31:0] gain_q;
  logic [15:0] t0_q;
  logic [15:0] rise_q;
  logic [15:0] decay_q;
  logic [23:0] base_q;
  logic [9:0]  rdelay_q;
  logic [31:0] rgain_q;
  logic        rmode_q;

  pulse_t pending_pulses[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     timed_out = 1'b0;
  bit     calm = 1'b0;
  int     hold_off = 0;

  always #6 clk_i = ~clk_i;

  exp_fermi_pulse_template_generator u_dut (.*);

  // exp(-x), x in Q.20, result in Q.16
  function automatic logic [63:0] exp_neg_q16(logic [63:0] x);
    logic [63:0] y, n, r;
    if (x > (64'd1 << 40)) x = 64'd1 << 40;
    y = (x * 64'd94548) >> 28;
    n = y >> 8;
    if (n >= 31) return 64'd0;
    r = 64'd1 << 30;
    for (int k = 0; k < 8; k++)
      if (y[7-k]) r = (r * 64'(FRAC_STEP[k]) + 64'd32768) >> 16;
    r = r >> n;
    return (r + 64'd8192) >> 14;
  endfunction

  function automatic pulse_t template_value(logic [15:0] t);
    longint d, u, sum;
    logic [63:0] dt, dec, fer, e, den, a, main_term, mag, g, refl;
    pulse_t p;
    d = longint'($signed(t)) - longint'($signed(t0_q));
    dt = d < 0 ? 64'd0 : 64'(d);
    dec = exp_neg_q16(dt * 64'(decay_q));
    if (rmode_q) dec += 64'd655;
    u = d * longint'(rise_q);
    if (u >= 0) begin
      e = exp_neg_q16(64'(u));
      den = 64'd65536 + e;
      fer = ((64'd1 << 32) + den / 2) / den;
    end else begin
      e = exp_neg_q16(64'(-u));
      den = 64'd65536 + e;
      fer = (e * 64'd65536 + den / 2) / den;
    end
    a = (64'(gain_q) * dec + 64'd32768) >> 16;
    main_term = (a * fer + (64'd1 << 23)) >> 24;
    sum = longint'(main_term) + longint'($signed(base_q));
    if (rmode_q) begin
      d = longint'(dt) - longint'(rdelay_q);
      mag = d < 0 ? 64'(-d) : 64'(d);
      g = exp_neg_q16(((mag * mag) * 64'd14564) >> 8);
      refl = (64'(rgain_q) * g + (64'd1 << 23)) >> 24;
      sum -= longint'(refl);
    end
    p.sat = 1'b0;
    if (sum > 64'sd2147483647) begin sum = 64'sd2147483647; p.sat = 1'b1; end
    if (sum < -64'sd2147483648) begin sum = -64'sd2147483648; p.sat = 1'b1; end
    p.value = sum[31:0];
    return p;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      efp_pkg::CFG_PEAK_GAIN:     gain_q = data;
      efp_pkg::CFG_START_TIME:    t0_q = data[15:0];
      efp_pkg::CFG_INV_RISE_TAU:  rise_q = data[15:0];
      efp_pkg::CFG_INV_DECAY_TAU: decay_q = data[15:0];
      efp_pkg::CFG_BASELINE:      base_q = data[23:0];
      efp_pkg::CFG_REFL_DELAY:    rdelay_q = data[9:0];
      efp_pkg::CFG_REFL_GAIN:     rgain_q = data;
      efp_pkg::CFG_REFL_MODE:     rmode_q = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] g, logic [15:0] t0, logic [15:0] rr,
                         logic [15:0] dd, logic [23:0] b, logic [9:0] rd,
                         logic [31:0] rg, logic m);
    write_reg(efp_pkg::CFG_PEAK_GAIN, g);
    write_reg(efp_pkg::CFG_START_TIME, {16'd0, t0});
    write_reg(efp_pkg::CFG_INV_RISE_TAU, {16'd0, rr});
    write_reg(efp_pkg::CFG_INV_DECAY_TAU, {16'd0, dd});
    write_reg(efp_pkg::CFG_BASELINE, {8'd0, b});
    write_reg(efp_pkg::CFG_REFL_DELAY, {22'd0, rd});
    write_reg(efp_pkg::CFG_REFL_GAIN, rg);
    write_reg(efp_pkg::CFG_REFL_MODE, {31'd0, m});
  endtask

  task automatic drain();
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // offer one word, hold it until accepted
  task automatic send_sample(logic [15:0] t);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_time_i <= t;
    pending_pulses.push_back(template_value(t));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_time();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      default: return 16'(int'($signed(t0_q)) + $urandom_range(0, 1500) - 200);
    endcase
  endfunction

  task automatic test_reset_defaults();
    gain_q = 0; t0_q = 0; rise_q = 16384; decay_q = 16384;
    base_q = 0; rdelay_q = 320; rgain_q = 0; rmode_q = 0;
    send_sample(16'h0000);
    send_sample(16'h0040);
    end_burst();
    drain();
  endtask

  task automatic test_directed();
    logic [15:0] t [10] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                            16'h0140, 16'hFFC0, 16'h0100, 16'h5555, 16'hAAAA};
    set_all(32'h0100_0000, 16'h0000, 16'h4000, 16'h2000, 24'h000100,
            10'd320, 32'h0080_0000, 1'b0);
    foreach (t[i]) send_sample(t[i]);
    end_burst(); drain();
    // reflection, both time constants zero
    set_all(32'hFFFF_FFFF, 16'h0200, 16'h0000, 16'h0000, 24'h800000,
            10'd0, 32'hFFFF_FFFF, 1'b1);
    foreach (t[i]) send_sample(t[i]);
    end_burst(); drain();
    // extreme gain, baseline and reflection settings at the ends of the time range
    set_all(32'hFFFF_FFFF, 16'h8000, 16'hFFFF, 16'h0000, 24'h7FFFFF,
            10'd1023, 32'h0, 1'b1);
    send_sample(16'h7FFF);
    end_burst(); drain();
    write_reg(efp_pkg::CFG_START_TIME, 32'h0000_7FFF);
    send_sample(16'h8000);
    end_burst(); drain();
    set_all(32'h0, 16'h7FFF, 16'hFFFF, 16'hFFFF, 24'h800000,
            10'd0, 32'hFFFF_FFFF, 1'b1);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    end_burst(); drain();
  endtask

  task automatic random_config();
    set_all($urandom, 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000)),
            16'($urandom), 16'($urandom_range(0, 3) == 0 ? $urandom
                                                        : $urandom_range(0, 4000)),
            24'($urandom), 10'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      random_config();
      for (int i = 0; i < per_phase; i++) send_sample(rand_time());
      end_burst();
      drain();
    end
  endtask

  task automatic test_back_pressure();
    random_config();
    hold_off = 60;
    for (int i = 0; i < 60; i++) send_sample(rand_time());
    end_burst();
    drain();
  endtask

  task automatic test_quiet_tail();
    calm = 1'b1;
    random_config();
    for (int i = 0; i < 150; i++) send_sample(rand_time());
    end_burst();
    drain();
  endtask

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (!out_ready_i) begin
      out_ready_i <= $urandom_range(0, 3) != 0;
    end else begin
      out_ready_i <= $urandom_range(0, 7) != 0;
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    pulse_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", pulse_value_o);
      end else begin
        want = pending_pulses.pop_front();
        if (pulse_value_o !== want.value || saturated_o !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value exp %h got %h, sat exp %b got %b",
                     want.value, pulse_value_o, want.sat, saturated_o);
        end
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i
        || pending_pulses.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_back_pressure();
    test_random(12, 140);
    test_quiet_tail();
    if (mismatches == 0 && pending_pulses.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
